@@ rtl/contour_edge_scorer_macros.svh @@
// Assertion macros for the contour edge scorer.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef CONTOUR_EDGE_SCORER_MACROS_SVH
`define CONTOUR_EDGE_SCORER_MACROS_SVH

// same-cycle implication
`define CES_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CES_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ces_pkg.sv @@
// Shared types and constants for the contour edge scorer.
// No dependencies.
package ces_pkg;

	localparam int COORD_BITS = 12;
	localparam int SUM_BITS   = 24;

	localparam int PT_BITS    = 12;
	localparam int STR_BITS   = 8;
	localparam int BOX_BITS   = 13;
	localparam int SHIFT_BITS = 12;
	localparam int SCORE_BITS = 22;
	localparam int TOTAL_BITS = 32;
	localparam int PERIM_BITS = BOX_BITS + 2;
	localparam int ADDR_BITS  = 5;
	localparam int DATA_BITS  = 32;

	localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

	typedef enum logic [2:0] {
		REG_BOX_LEFT   = 3'd0,
		REG_BOX_TOP    = 3'd1,
		REG_BOX_WIDTH  = 3'd2,
		REG_BOX_HEIGHT = 3'd3,
		REG_SHIFT_X    = 3'd4,
		REG_SHIFT_Y    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [BOX_BITS-1:0]   box_left;
		logic [BOX_BITS-1:0]   box_top;
		logic [BOX_BITS-1:0]   box_width;
		logic [BOX_BITS-1:0]   box_height;
		logic [SHIFT_BITS-1:0] shift_x;
		logic [SHIFT_BITS-1:0] shift_y;
	} cfg_t;

	typedef struct packed {
		logic [PT_BITS-1:0]  point_x;
		logic [PT_BITS-1:0]  point_y;
		logic [STR_BITS-1:0] edge_strength;
		logic                contour_end;
		logic                frame_end;
	} point_t;

	// contour close request toward the divider
	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic                frame_end;
	} div_req_t;

	// divider result, held until taken
	typedef struct packed {
		logic                  valid;
		logic [SCORE_BITS-1:0] score;
		logic                  frame_end;
	} div_res_t;

endpackage

@@ rtl/ces_point_if.sv @@
// Point channel: valid/ready plus one contour point.
// Depends on ces_pkg.
interface ces_point_if import ces_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PT_BITS-1:0]  point_x;
	logic [PT_BITS-1:0]  point_y;
	logic [STR_BITS-1:0] edge_strength;
	logic                contour_end;
	logic                frame_end;

	modport source (output valid, point_x, point_y, edge_strength, contour_end, frame_end,
		input ready);
	modport sink (input valid, point_x, point_y, edge_strength, contour_end, frame_end,
		output ready);
endinterface

@@ rtl/ces_score_if.sv @@
// Score channel: valid/ready plus one contour result.
// Depends on ces_pkg.
interface ces_score_if import ces_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SCORE_BITS-1:0] contour_score;
	logic [TOTAL_BITS-1:0] total_score;
	logic                  total_final;

	modport source (output valid, contour_score, total_score, total_final, input ready);
	modport sink (input valid, contour_score, total_score, total_final, output ready);
endinterface

@@ rtl/ces_regs.sv @@
// APB register file holding box and offset settings.
// Depends on ces_pkg.
module ces_regs import ces_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_left   <= '0;
			cfg_q.box_top    <= '0;
			cfg_q.box_width  <= BOX_BITS'(1);
			cfg_q.box_height <= BOX_BITS'(1);
			cfg_q.shift_x    <= '0;
			cfg_q.shift_y    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BOX_LEFT:   cfg_q.box_left   <= pwdata[BOX_BITS-1:0];
				REG_BOX_TOP:    cfg_q.box_top    <= pwdata[BOX_BITS-1:0];
				REG_BOX_WIDTH:  cfg_q.box_width  <= pwdata[BOX_BITS-1:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= pwdata[BOX_BITS-1:0];
				REG_SHIFT_X:    cfg_q.shift_x    <= pwdata[SHIFT_BITS-1:0];
				REG_SHIFT_Y:    cfg_q.shift_y    <= pwdata[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BOX_LEFT:   prdata = DATA_BITS'(cfg_q.box_left);
			REG_BOX_TOP:    prdata = DATA_BITS'(cfg_q.box_top);
			REG_BOX_WIDTH:  prdata = DATA_BITS'(cfg_q.box_width);
			REG_BOX_HEIGHT: prdata = DATA_BITS'(cfg_q.box_height);
			REG_SHIFT_X:    prdata = DATA_BITS'(cfg_q.shift_x);
			REG_SHIFT_Y:    prdata = DATA_BITS'(cfg_q.shift_y);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ rtl/ces_point.sv @@
// Per-point path: box test, peak/sum/keep tracking, contour close request.
// Depends on ces_pkg.
module ces_point import ces_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  point_t   pt,
	input  cfg_t     cfg,
	output div_req_t req
);

	localparam int AW = BOX_BITS + 1;
	localparam logic [PT_BITS-1:0] CMASK = PT_BITS'((64'd1 << COORD_BITS) - 64'd1);
	localparam int KW = STR_BITS + 3;

	logic [STR_BITS-1:0] peak_q;
	logic [SUM_BITS-1:0] sum_q;
	logic                keep_q;

	logic [AW-1:0]       px, py, x_end, y_end;
	logic                in_box, close, keep_out;
	logic [SUM_BITS:0]   sum_add;
	logic [SUM_BITS-1:0] sum_nxt;
	logic [STR_BITS-1:0] peak_nxt;
	logic                keep_nxt;
	logic [KW-1:0]       s5;

	assign px     = AW'(pt.point_x & CMASK) + AW'(cfg.shift_x);
	assign py     = AW'(pt.point_y & CMASK) + AW'(cfg.shift_y);
	assign x_end  = AW'(cfg.box_left) + AW'(cfg.box_width);
	assign y_end  = AW'(cfg.box_top) + AW'(cfg.box_height);
	assign in_box = (px >= AW'(cfg.box_left)) && (px < x_end) &&
		(py >= AW'(cfg.box_top)) && (py < y_end);
	assign close  = pt.contour_end || pt.frame_end;

	// s < floor(peak/5)  <=>  5*(s+1) <= peak
	assign s5       = (KW'(pt.edge_strength) + KW'(1)) * KW'(5);
	assign keep_out = s5 <= KW'(peak_q);
	assign sum_add  = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(pt.edge_strength);

	always_comb begin
		peak_nxt = peak_q;
		sum_nxt  = sum_q;
		keep_nxt = keep_q;
		if (in_box) begin
			if (keep_q) begin
				if (pt.edge_strength > peak_q) peak_nxt = pt.edge_strength;
				sum_nxt = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
			end else begin
				sum_nxt = '0;
			end
		end else begin
			keep_nxt = keep_out;
		end
	end

	assign req.start     = accept && close;
	assign req.dividend  = sum_nxt;
	assign req.frame_end = pt.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			sum_q  <= '0;
			keep_q <= 1'b1;
		end else if (accept) begin
			if (close) begin
				peak_q <= '0;
				sum_q  <= '0;
				keep_q <= 1'b1;
			end else begin
				peak_q <= peak_nxt;
				sum_q  <= sum_nxt;
				keep_q <= keep_nxt;
			end
		end
	end

endmodule

@@ rtl/ces_divider.sv @@
// Bit-serial restoring divider: contour sum over box perimeter.
// Depends on ces_pkg.
module ces_divider import ces_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	input  logic [PERIM_BITS-1:0] perim,
	input  logic                  ack,
	output logic                  idle,
	output div_res_t              res
);

	localparam int CW = $clog2(SUM_BITS + 1);
	localparam int QW = (SUM_BITS > SCORE_BITS) ? SUM_BITS : SCORE_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [SUM_BITS-1:0]   dq_q;
	logic [PERIM_BITS-1:0] rem_q;
	logic [PERIM_BITS-1:0] div_q;
	logic [CW-1:0]         cnt_q;
	logic                  fend_q;

	logic [PERIM_BITS:0]   trial;
	logic                  qbit;
	logic [QW-1:0]         q_ext;
	logic [SCORE_BITS-1:0] score_sat;

	assign trial = {rem_q, dq_q[SUM_BITS-1]};
	assign qbit  = trial >= {1'b0, div_q};
	assign q_ext = QW'(dq_q);

	assign idle          = state_q == ST_IDLE;
	assign res.valid     = state_q == ST_DONE;
	assign res.frame_end = fend_q;
	assign res.score     = score_sat;
	always_comb begin
		if (div_q == '0)                 score_sat = '0;
		else if (q_ext > QW'(SCORE_MAX)) score_sat = SCORE_MAX;
		else                             score_sat = q_ext[SCORE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_RUN;
						cnt_q   <= CW'(SUM_BITS);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			dq_q   <= req.dividend;
			rem_q  <= '0;
			div_q  <= perim;
			fend_q <= req.frame_end;
		end else if (state_q == ST_RUN) begin
			rem_q <= qbit ? PERIM_BITS'(trial - {1'b0, div_q}) : trial[PERIM_BITS-1:0];
			dq_q  <= {dq_q[SUM_BITS-2:0], qbit};
		end
	end

endmodule

@@ rtl/contour_edge_scorer.sv @@
// Contour edge scorer. Ordinary points: one transfer per cycle while the divider is
// idle, no result. Contour or frame end: the divider works through the sum one bit
// at a time, then the result is loaded into the output register; the next point is
// taken only after the divider returns to idle, which output back-pressure delays.
// Async active-low reset: registers to their reset values, peak and sum clear,
// keep flag set, running total zero.
`include "contour_edge_scorer_macros.svh"

module contour_edge_scorer import ces_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	ces_point_if.sink            pt,
	ces_score_if.source          sc
);

	cfg_t     cfg;
	point_t   pt_data;
	div_req_t req;
	div_res_t res;
	logic     div_idle;
	logic     accept;
	logic     out_load;

	logic [PERIM_BITS-1:0] perim;
	logic [TOTAL_BITS:0]   total_sum;
	logic [TOTAL_BITS-1:0] total_nxt;

	// running total and output register
	logic [TOTAL_BITS-1:0] total_q;
	logic                  out_valid_q;
	logic [SCORE_BITS-1:0] out_score_q;
	logic [TOTAL_BITS-1:0] out_total_q;
	logic                  out_final_q;

	ces_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign pt_data.point_x       = pt.point_x;
	assign pt_data.point_y       = pt.point_y;
	assign pt_data.edge_strength = pt.edge_strength;
	assign pt_data.contour_end   = pt.contour_end;
	assign pt_data.frame_end     = pt.frame_end;

	// points flow while the divider is free; a contour close parks the input
	assign pt.ready = div_idle;
	assign accept   = pt.valid && pt.ready;

	ces_point u_point (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pt     (pt_data),
		.cfg    (cfg),
		.req    (req)
	);

	// perimeter 2w+2h, latched by the divider at start
	assign perim = {PERIM_BITS'(cfg.box_width) + PERIM_BITS'(cfg.box_height)} << 1;

	ces_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.perim  (perim),
		.ack    (out_load),
		.idle   (div_idle),
		.res    (res)
	);

	// result moves out when the output register is empty or being drained
	assign out_load  = res.valid && (!out_valid_q || sc.ready);
	assign total_sum = (TOTAL_BITS+1)'(total_q) + (TOTAL_BITS+1)'(res.score);
	assign total_nxt = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				total_q     <= res.frame_end ? '0 : total_nxt;
				out_valid_q <= 1'b1;
			end else if (sc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_score_q <= res.score;
			out_total_q <= total_nxt;
			out_final_q <= res.frame_end;
		end
	end

	assign sc.valid         = out_valid_q;
	assign sc.contour_score = out_score_q;
	assign sc.total_score   = out_total_q;
	assign sc.total_final   = out_final_q;

	// a contour close always parks the input behind the divider
	`CES_ASSERT_NXT(a_close_blocks, accept && (pt.contour_end || pt.frame_end), !pt.ready, "input not held during division")
	// frame end clears the running total
	`CES_ASSERT_NXT(a_frame_clears, out_load && res.frame_end, total_q == '0, "total not cleared at frame end")
	// no result overwrites one that is still waiting
	`CES_ASSERT_IMP(a_no_overrun, out_load, !(sc.valid && !sc.ready), "result overwritten")

endmodule

@@ bench/tb_contour_edge_scorer.sv @@
// Testbench for contour_edge_scorer: directed rows, then random contour streams.
// Results are checked against a local model or typed rows; registers go over APB.
// Depends on ces_pkg, ces_point_if, ces_score_if and the contour_edge_scorer RTL.
module tb_contour_edge_scorer;
	import ces_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 6;
	// margin left before touching registers
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int IDLE_PCT      = 26;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POINTS  = 150;
	// phase with no idling on either side
	localparam int CALM_PHASE    = 3;
	localparam int AIM_PCT       = 65;
	localparam int KEEP_RATIO    = 5;

	typedef struct packed {
		logic [SCORE_BITS-1:0] contour_score;
		logic [TOTAL_BITS-1:0] total_score;
		logic                  total_final;
	} result_t;

	typedef enum logic {ROW_POINT, ROW_CONFIG} row_kind_t;

	// one line of the directed plan
	typedef struct {
		row_kind_t   kind;
		point_t      pt;
		int unsigned reps;
		cfg_t        cfg;
		bit          typed;
		result_t     want;
	} row_t;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [ADDR_BITS-1:0] paddr   = '0;
	logic [DATA_BITS-1:0] pwdata  = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	ces_point_if pt_ch ();
	ces_score_if sc_ch ();

	contour_edge_scorer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pt      (pt_ch),
		.sc      (sc_ch)
	);

	// model state, mirrors the block after reset
	cfg_t                cfg_shadow = '{box_left: '0, box_top: '0, box_width: 13'd1,
		box_height: 13'd1, shift_x: '0, shift_y: '0};
	logic [STR_BITS-1:0]   peak_q  = '0;
	logic [SUM_BITS-1:0]   sum_q   = '0;
	logic                  keep_q  = 1'b1;
	logic [TOTAL_BITS-1:0] total_q = '0;

	result_t     score_q[$];   // contour results still owed by the block
	int unsigned points_sent  = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count   = 0;
	int unsigned settings_run = 0;
	int unsigned cycle_count  = 0;
	bit          calm         = 1'b0;

	initial begin
		pt_ch.valid         = 1'b0;
		pt_ch.point_x       = '0;
		pt_ch.point_y       = '0;
		pt_ch.edge_strength = '0;
		pt_ch.contour_end   = 1'b0;
		pt_ch.frame_end     = 1'b0;
		sc_ch.ready         = 1'b0;
	end

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout, %0d results still owed", $time, score_q.size());
		$display("tb_contour_edge_scorer NOT OK");
		$finish;
	end

	// Scoring model: one accepted point in, at most one contour result out.
	function automatic bit score_point(input point_t p, output result_t r);
		logic [BOX_BITS:0]     px;
		logic [BOX_BITS:0]     py;
		logic [SUM_BITS:0]     acc;
		logic [PERIM_BITS-1:0] perim;
		logic [SUM_BITS-1:0]   quot;
		logic [TOTAL_BITS:0]   tot;
		logic                  in_box;
		r = '0;
		px = p.point_x + cfg_shadow.shift_x;
		py = p.point_y + cfg_shadow.shift_y;
		in_box = px >= cfg_shadow.box_left &&
			px < {1'b0, cfg_shadow.box_left} + cfg_shadow.box_width &&
			py >= cfg_shadow.box_top &&
			py < {1'b0, cfg_shadow.box_top} + cfg_shadow.box_height;
		if (in_box) begin
			if (keep_q) begin
				if (p.edge_strength > peak_q)
					peak_q = p.edge_strength;
				acc = sum_q + p.edge_strength;
				sum_q = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_BITS-1:0];
			end else begin
				sum_q = '0;
			end
		end else begin
			// outside the box the strength decides whether the next inside run counts
			keep_q = p.edge_strength < peak_q / KEEP_RATIO;
		end
		// frame end alone also closes the contour
		if (!(p.contour_end || p.frame_end))
			return 1'b0;
		perim = PERIM_BITS'(2 * cfg_shadow.box_width + 2 * cfg_shadow.box_height);
		quot = (perim == '0) ? '0 : sum_q / perim;
		r.contour_score = (quot > SCORE_MAX) ? SCORE_MAX : quot[SCORE_BITS-1:0];
		tot = total_q + r.contour_score;
		total_q = (tot > TOTAL_MAX) ? TOTAL_MAX : tot[TOTAL_BITS-1:0];
		r.total_score = total_q;
		r.total_final = p.frame_end;
		if (p.frame_end)
			total_q = '0;
		peak_q = '0;
		sum_q  = '0;
		keep_q = 1'b1;
		return 1'b1;
	endfunction

	// Entered and left at a falling edge with nothing yet driven in that step.
	task automatic send_point(input point_t p, input bit typed, input result_t want);
		result_t due;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			pt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pt_ch.valid         <= 1'b1;
		pt_ch.point_x       <= p.point_x;
		pt_ch.point_y       <= p.point_y;
		pt_ch.edge_strength <= p.edge_strength;
		pt_ch.contour_end   <= p.contour_end;
		pt_ch.frame_end     <= p.frame_end;
		do @(posedge clk); while (!pt_ch.ready);
		points_sent++;
		// typed rows carry a hand-worked expectation; the model still advances
		if (score_point(p, due))
			score_q = {score_q, (typed ? want : due)};
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed result, then let the divider drain.
	task automatic wait_idle();
		pt_ch.valid <= 1'b0;
		while (score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// APB transfer: setup, access, then idle; returns at a falling edge.
	task automatic reg_access(input reg_idx_t idx, input bit wr,
		input logic [DATA_BITS-1:0] wdat, output logic [DATA_BITS-1:0] rdat);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdat;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdat = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Program all six registers while the block is quiet, then read them back.
	task automatic load_box(input cfg_t c);
		logic [DATA_BITS-1:0] vals [reg_idx_t];
		logic [DATA_BITS-1:0] rd;
		reg_idx_t             idx;
		wait_idle();
		vals[REG_BOX_LEFT]   = c.box_left;
		vals[REG_BOX_TOP]    = c.box_top;
		vals[REG_BOX_WIDTH]  = c.box_width;
		vals[REG_BOX_HEIGHT] = c.box_height;
		vals[REG_SHIFT_X]    = c.shift_x;
		vals[REG_SHIFT_Y]    = c.shift_y;
		idx = idx.first();
		repeat (idx.num()) begin
			reg_access(idx, 1'b1, vals[idx], rd);
			idx = idx.next();
		end
		idx = idx.first();
		repeat (idx.num()) begin
			reg_access(idx, 1'b0, '0, rd);
			if (rd !== vals[idx]) begin
				fail_count++;
				$display("%0t: readback %s expected %0d actual %0d", $time, idx.name(),
					vals[idx], rd);
			end
			idx = idx.next();
		end
		cfg_shadow = c;
		settings_run++;
	endtask

	function automatic row_t point_row(input int unsigned x, y, s, ce, fe,
		input int unsigned reps = 1);
		row_t r;
		r.kind  = ROW_POINT;
		r.pt    = '{point_x: x, point_y: y, edge_strength: s, contour_end: ce, frame_end: fe};
		r.reps  = reps;
		r.cfg   = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic row_t typed_row(input int unsigned x, y, s, ce, fe,
		input longint unsigned score, total, input bit fin);
		row_t r;
		r = point_row(x, y, s, ce, fe);
		r.typed = 1'b1;
		r.want  = '{contour_score: score, total_score: total, total_final: fin};
		return r;
	endfunction

	function automatic row_t box_row(input int unsigned l, t, w, h, sx, sy);
		row_t r;
		r = point_row(0, 0, 0, 0, 0);
		r.kind = ROW_CONFIG;
		r.cfg  = '{box_left: l, box_top: t, box_width: w, box_height: h, shift_x: sx,
			shift_y: sy};
		return r;
	endfunction

	// Register setting per random phase: a few fixed corners, the rest random but
	// with the box placed where shifted points can land.
	function automatic cfg_t pick_box(input int ph);
		cfg_t c;
		case (ph)
			0: c = '{box_left: '0, box_top: '0, box_width: 13'd4096, box_height: 13'd4096,
				shift_x: '0, shift_y: '0};
			1: c = '{box_left: '0, box_top: '0, box_width: 13'd1, box_height: 13'd1,
				shift_x: '0, shift_y: '0};
			2: c = '{box_left: 13'd8190, box_top: 13'd8190, box_width: 13'd4096,
				box_height: 13'd4096, shift_x: 12'd4095, shift_y: 12'd4095};
			default: begin
				c.shift_x    = $urandom_range(0, 4095);
				c.shift_y    = $urandom_range(0, 4095);
				c.box_left   = $urandom_range(c.shift_x, c.shift_x + 4095);
				c.box_top    = $urandom_range(c.shift_y, c.shift_y + 4095);
				c.box_width  = $urandom_range(0, 1) ? $urandom_range(1, 64) :
					$urandom_range(1, 4096);
				c.box_height = $urandom_range(0, 1) ? $urandom_range(1, 64) :
					$urandom_range(1, 4096);
			end
		endcase
		return c;
	endfunction

	// Random point; when aimed, steer it into the box if the shift allows.
	function automatic point_t make_point(input bit aim);
		point_t p;
		int     tx;
		int     ty;
		p.point_x = $urandom_range(0, 4095);
		p.point_y = $urandom_range(0, 4095);
		if (aim) begin
			tx = int'(cfg_shadow.box_left) + int'($urandom_range(0, cfg_shadow.box_width - 1))
				- int'(cfg_shadow.shift_x);
			ty = int'(cfg_shadow.box_top) + int'($urandom_range(0, cfg_shadow.box_height - 1))
				- int'(cfg_shadow.shift_y);
			if (tx >= 0 && tx <= 4095)
				p.point_x = tx;
			if (ty >= 0 && ty <= 4095)
				p.point_y = ty;
		end
		// weak strengths outside the box keep the keep flag moving both ways
		p.edge_strength = (aim || $urandom_range(0, 1)) ? $urandom_range(0, 255) :
			$urandom_range(0, 20);
		p.contour_end = $urandom_range(0, 9) == 0;
		p.frame_end   = $urandom_range(0, 39) == 0;
		return p;
	endfunction

	// result side: random back-pressure, none during calm stretches
	always @(negedge clk) begin
		sc_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// every result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		result_t want;
		if (arst_n && sc_ch.valid && sc_ch.ready) begin
			if (score_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result score %0d total %0d final %0b", $time,
					sc_ch.contour_score, sc_ch.total_score, sc_ch.total_final);
			end else begin
				want = score_q.pop_front();
				results_seen++;
				if (sc_ch.contour_score !== want.contour_score ||
					sc_ch.total_score !== want.total_score ||
					sc_ch.total_final !== want.total_final) begin
					fail_count++;
					$display("%0t: expected score %0d total %0d final %0b, actual %0d %0d %0b",
						$time, want.contour_score, want.total_score, want.total_final,
						sc_ch.contour_score, sc_ch.total_score, sc_ch.total_final);
				end
			end
		end
	end

	initial begin
		row_t    plan[$];
		result_t none;
		none = '0;

		// reset setting: the box is the single pixel (0,0), perimeter 4
		plan = {plan, typed_row(0, 0, 200, 1, 0, 50, 50, 0)};
		// frame end without contour end still closes the contour
		plan = {plan, typed_row(0, 0, 255, 0, 1, 63, 113, 1)};
		// outside with zero peak: flag clears, inside point then zeroes the sum
		plan = {plan, point_row(4095, 4095, 0, 0, 0)};
		plan = {plan, point_row(0, 0, 100, 0, 0)};
		plan = {plan, typed_row(0, 0, 0, 1, 1, 0, 0, 1)};
		// weak outside point keeps the run, strong one drops it
		plan = {plan, point_row(0, 0, 250, 0, 0)};
		plan = {plan, point_row(1, 1, 10, 0, 0)};
		plan = {plan, point_row(0, 0, 100, 0, 0)};
		plan = {plan, point_row(1, 1, 60, 0, 0)};
		plan = {plan, point_row(0, 0, 50, 0, 0)};
		plan = {plan, point_row(0, 0, 7, 1, 0)};
		// largest box and shifts: all but the far corner point land inside
		plan = {plan, box_row(4000, 4000, 4096, 4096, 4095, 4095)};
		plan = {plan, point_row(0, 0, 255, 0, 0)};
		plan = {plan, point_row(4095, 4095, 255, 0, 0)};
		plan = {plan, point_row(2048, 2048, 128, 1, 0)};
		// box beyond reach of any shifted point
		plan = {plan, box_row(8191, 8191, 4096, 4096, 4095, 4095)};
		plan = {plan, point_row(4095, 4095, 255, 1, 1)};
		// zero width and height: nothing inside, score forced to zero
		plan = {plan, box_row(0, 0, 0, 0, 0, 0)};
		plan = {plan, typed_row(0, 0, 255, 1, 1, 0, 0, 1)};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CONFIG) begin
				load_box(plan[i].cfg);
			end else begin
				calm = plan[i].reps > 1;
				repeat (plan[i].reps) send_point(plan[i].pt, plan[i].typed, plan[i].want);
				calm = 1'b0;
			end
		end

		// random contours, one register setting per phase
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_box(pick_box(ph));
			calm = (ph == CALM_PHASE);
			repeat (PHASE_POINTS)
				send_point(make_point($urandom_range(0, 99) < AIM_PCT), 1'b0, none);
			calm = 1'b0;
		end

		wait_idle();
		$display("Covered %0d point transfers under %0d register settings,", points_sent,
			settings_run);
		$display("%0d contour results compared, %0d failures.", results_seen, fail_count);
		if (fail_count == 0) begin
			$display("tb_contour_edge_scorer OK");
		end else begin
			$display("tb_contour_edge_scorer NOT OK");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ces_pkg.sv
rtl/ces_point_if.sv
rtl/ces_score_if.sv
rtl/ces_regs.sv
rtl/ces_point.sv
rtl/ces_divider.sv
rtl/contour_edge_scorer.sv
bench/tb_contour_edge_scorer.sv
